// ----- rtl/pit_pkg.sv -----
`default_nettype none

package pit_pkg;

    // Field widths
    localparam int KEY_W     = 32;
    localparam int LEN_W     = 6;
    localparam int PORT_W    = 8;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int OUT_IDX_W = 10;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPLY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    localparam logic [LEN_W-1:0] FULL_LEN = 6'd32;
    localparam logic [KEY_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [KEY_W-1:0]  first_value;
        logic [KEY_W-1:0]  second_value;
        logic [LEN_W-1:0]  prefix_len;
        logic [PORT_W-1:0] port_id;
    } t_req;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] interval_index;
        logic [STAT_W-1:0]    status;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUP_WAIT,
        ST_SHIFT,
        ST_FIND_WAIT,
        ST_APPLY,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MODE_HOLD,
        MODE_DUP,
        MODE_SHIFT,
        MODE_FIND,
        MODE_APPLY
    } t_mode;

    // Broadcast from the controller to every cell
    typedef struct packed {
        t_mode             mode;
        logic [KEY_W-1:0]  key_a;
        logic [KEY_W-1:0]  key_b;
        logic [LEN_W-1:0]  len;
        logic [PORT_W-1:0] port;
    } t_cell_cmd;

    // Handed from one cell to the next
    typedef struct packed {
        logic [KEY_W-1:0] ep;
        logic             valid;
        logic             lt;
        logic             ge_b;
    } t_link;

endpackage

`default_nettype wire

// ----- rtl/pit_cell.sv -----
`default_nettype none

module pit_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire pit_pkg::t_cell_cmd        i_cmd,
    input  wire pit_pkg::t_link            i_prev,
    output pit_pkg::t_link                 o_link,
    output logic [IDX_W:0]                 o_leaf
);

    localparam bit IS_HEAD     = (CELL_IDX == 0);
    localparam bit PREV_COUNTS = (CELL_IDX >= 2);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [pit_pkg::KEY_W-1:0]  r_ep,    n_ep;
    logic                       r_valid, n_valid;
    logic [pit_pkg::PORT_W-1:0] r_port,  n_port;
    logic [pit_pkg::LEN_W-1:0]  r_len,   n_len;

    logic w_below_a;
    logic w_lt;
    logic w_ge_a;
    logic w_ge_b;
    logic w_eq;
    logic w_prev_ge_a;
    logic w_prev_ge_b;
    logic w_hit;
    logic w_cover;

    // Compare the stored endpoint against both keys
    assign w_below_a   = (r_ep < i_cmd.key_a);
    assign w_lt        = r_valid & w_below_a;
    assign w_ge_a      = r_valid & ~w_below_a;
    assign w_ge_b      = r_valid & (r_ep >= i_cmd.key_b);
    assign w_eq        = r_valid & (r_ep == i_cmd.key_a);

    // Entry zero never takes part in lookups or prefix walks
    assign w_prev_ge_a = PREV_COUNTS & i_prev.valid & ~i_prev.lt;
    assign w_prev_ge_b = PREV_COUNTS & i_prev.ge_b;
    assign w_hit       = ~IS_HEAD & w_ge_a & ~w_prev_ge_a;
    assign w_cover     = ~IS_HEAD & w_ge_a & ~w_prev_ge_b;

    assign o_link = '{ep: r_ep, valid: r_valid, lt: w_lt, ge_b: w_ge_b};

    // Drive the reduction leaf
    always_comb begin
        case (i_cmd.mode)
            pit_pkg::MODE_DUP:  o_leaf = {w_eq, {IDX_W{1'b0}}};
            pit_pkg::MODE_FIND: o_leaf = {w_hit, (w_hit ? MY_IDX : {IDX_W{1'b0}})};
            default:            o_leaf = '0;
        endcase
    end

    // Shift right past the insert point, or take the prefix port and length
    always_comb begin
        n_ep    = r_ep;
        n_valid = r_valid;
        n_port  = r_port;
        n_len   = r_len;
        case (i_cmd.mode)
            pit_pkg::MODE_SHIFT: begin
                if (!IS_HEAD && !w_lt) begin
                    if (i_prev.lt) begin
                        n_ep    = i_cmd.key_a;
                        n_valid = 1'b1;
                    end else begin
                        n_ep    = i_prev.ep;
                        n_valid = i_prev.valid;
                    end
                end
            end
            pit_pkg::MODE_APPLY: begin
                if (w_cover && (r_len <= i_cmd.len)) begin
                    n_len  = i_cmd.len;
                    n_port = i_cmd.port;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep    <= '0;
            r_valid <= IS_HEAD;
            r_port  <= '0;
            r_len   <= '0;
        end else begin
            r_ep    <= n_ep;
            r_valid <= n_valid;
            r_port  <= n_port;
            r_len   <= n_len;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pit_or_tree.sv -----
`default_nettype none

module pit_or_tree #(
    parameter int N = 1024,
    parameter int W = 11
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_leaf [N],
    output logic [W-1:0]      o_root
);

    // Radix-4 levels, one register stage each
    localparam int LV  = ($clog2(N) + 1) / 2;
    localparam int PAD = 4 ** LV;
    localparam int TOT = (PAD - 1) / 3;

    logic [W-1:0] w_pad  [PAD];
    logic [W-1:0] n_node [TOT];
    logic [W-1:0] r_node [TOT];

    // Pad the leaf row with zeros
    for (genvar gj = 0; gj < PAD; gj++) begin : g_pad
        if (gj < N) begin : g_real
            assign w_pad[gj] = i_leaf[gj];
        end else begin : g_zero
            assign w_pad[gj] = '0;
        end
    end

    // Level m holds 4**m nodes starting at (4**m - 1) / 3
    for (genvar gm = 0; gm < LV; gm++) begin : g_lvl
        localparam int OFF  = (4 ** gm - 1) / 3;
        localparam int COFF = (4 ** (gm + 1) - 1) / 3;
        for (genvar gj = 0; gj < 4 ** gm; gj++) begin : g_node
            if (gm == LV - 1) begin : g_bottom
                assign n_node[OFF+gj] = w_pad[4*gj] | w_pad[4*gj+1]
                                      | w_pad[4*gj+2] | w_pad[4*gj+3];
            end else begin : g_inner
                assign n_node[OFF+gj] = r_node[COFF+4*gj] | r_node[COFF+4*gj+1]
                                      | r_node[COFF+4*gj+2] | r_node[COFF+4*gj+3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
    end

    assign o_root = r_node[0];

endmodule

`default_nettype wire

// ----- rtl/prefix_interval_table_unit.sv -----
`default_nettype none

// Sorted interval endpoint table with per-interval port and prefix length.
// Request channel (i_req_valid / o_req_ready, payload i_req): insert an endpoint
// pair, apply a prefix port, or look up the first interval whose endpoint is at
// least a key. Response channel (o_res_valid / i_res_ready, payload o_res): one
// response per request, in request order.
// Every table entry is one cell of a chain; cells compare in parallel and hand
// their endpoint and compare flags to the next cell. Results that need the whole
// table (duplicate check, lookup index) pass a registered radix-4 OR tree of
// LV = ceil(log4(TABLE_DEPTH)) stages (5 at 1024 entries).
// Sequence per request: a refused insert or an unknown request goes straight to
// the response; apply updates the cells once; lookup waits for the tree result;
// insert waits for the duplicate check on each endpoint and shifts the chain for
// each endpoint actually added; every request ends by loading the response.
// One request is in work at a time; the next is taken the cycle after the previous
// response is loaded into the output register. A response waiting on a stalled
// receiver does not block the next request until that one finishes too.
// Reset empties the table to the single entry 0 with endpoint 0 and clears all
// ports and lengths.
module prefix_interval_table_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire pit_pkg::t_req i_req,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output pit_pkg::t_res      o_res
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LV     = ($clog2(TABLE_DEPTH) + 1) / 2;
    localparam int WAIT_W = $clog2(LV + 1);
    localparam int OW     = pit_pkg::OUT_IDX_W;

    pit_pkg::t_state r_state, n_state;

    logic [pit_pkg::KEY_W-1:0]  r_key_a,  n_key_a;
    logic [pit_pkg::KEY_W-1:0]  r_key_b,  n_key_b;
    logic [pit_pkg::KEY_W-1:0]  r_second, n_second;
    logic [pit_pkg::LEN_W-1:0]  r_len,    n_len;
    logic [pit_pkg::PORT_W-1:0] r_port,   n_port;
    logic                       r_phase,  n_phase;
    logic [WAIT_W-1:0]          r_wait,   n_wait;
    logic [CNT_W-1:0]           r_count,  n_count;
    pit_pkg::t_res              r_res,    n_res;
    pit_pkg::t_res              r_out,    n_out;
    logic                       r_out_valid, n_out_valid;

    logic                       w_accept;
    logic                       w_full;
    logic                       w_wait_done;
    logic                       w_out_free;
    logic [pit_pkg::LEN_W-1:0]  w_len_sat;
    logic [pit_pkg::KEY_W-1:0]  w_host;
    pit_pkg::t_mode             w_mode;
    pit_pkg::t_cell_cmd         w_cmd;
    logic [IDX_W:0]             w_root;
    logic                       w_root_hit;
    logic [OW-1:0]              w_root_idx;

    pit_pkg::t_link             w_link [TABLE_DEPTH];
    logic [IDX_W:0]             w_leaf [TABLE_DEPTH];
    pit_pkg::t_link             w_head_prev;

    assign w_accept    = i_req_valid & o_req_ready;
    assign w_full      = ({1'b0, r_count} + (CNT_W + 1)'(2)) > (CNT_W + 1)'(TABLE_DEPTH);
    assign w_wait_done = (r_wait == WAIT_W'(LV));
    assign w_out_free  = ~r_out_valid | i_res_ready;

    // Prefix range: clear host bits for the low end, set them for the high end
    assign w_len_sat = (i_req.prefix_len > pit_pkg::FULL_LEN) ? pit_pkg::FULL_LEN
                                                              : i_req.prefix_len;
    assign w_host    = pit_pkg::ALL_ONES >> w_len_sat;

    assign w_root_hit = w_root[IDX_W];
    if (IDX_W >= OW) begin : g_idx_trunc
        assign w_root_idx = w_root[OW-1:0];
    end else begin : g_idx_ext
        assign w_root_idx = {{(OW - IDX_W){1'b0}}, w_root[IDX_W-1:0]};
    end

    assign w_cmd = '{mode: w_mode, key_a: r_key_a, key_b: r_key_b,
                     len: r_len, port: r_port};

    // Cell chain
    assign w_head_prev = '0;
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            pit_cell #(.CELL_IDX(gi), .IDX_W(IDX_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_prev  (w_head_prev),
                .o_link  (w_link[gi]),
                .o_leaf  (w_leaf[gi])
            );
        end else begin : g_body
            pit_cell #(.CELL_IDX(gi), .IDX_W(IDX_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_prev  (w_link[gi-1]),
                .o_link  (w_link[gi]),
                .o_leaf  (w_leaf[gi])
            );
        end
    end

    pit_or_tree #(.N(TABLE_DEPTH), .W(IDX_W + 1)) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pit_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        pit_pkg::REQ_INSERT: n_state = w_full ? pit_pkg::ST_DONE
                                                              : pit_pkg::ST_DUP_WAIT;
                        pit_pkg::REQ_APPLY:  n_state = pit_pkg::ST_APPLY;
                        pit_pkg::REQ_LOOKUP: n_state = pit_pkg::ST_FIND_WAIT;
                        default:             n_state = pit_pkg::ST_DONE;
                    endcase
                end
            end
            pit_pkg::ST_DUP_WAIT: begin
                if (w_wait_done) begin
                    if (!w_root_hit) begin
                        n_state = pit_pkg::ST_SHIFT;
                    end else if (r_phase) begin
                        n_state = pit_pkg::ST_DONE;
                    end
                end
            end
            pit_pkg::ST_SHIFT: begin
                n_state = r_phase ? pit_pkg::ST_DONE : pit_pkg::ST_DUP_WAIT;
            end
            pit_pkg::ST_FIND_WAIT: begin
                if (w_wait_done) begin
                    n_state = pit_pkg::ST_DONE;
                end
            end
            pit_pkg::ST_APPLY: begin
                n_state = pit_pkg::ST_DONE;
            end
            pit_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = pit_pkg::ST_IDLE;
                end
            end
            default: n_state = pit_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_req_ready = 1'b0;
        w_mode      = pit_pkg::MODE_HOLD;
        case (r_state)
            pit_pkg::ST_IDLE:      o_req_ready = 1'b1;
            pit_pkg::ST_DUP_WAIT:  w_mode = pit_pkg::MODE_DUP;
            pit_pkg::ST_SHIFT:     w_mode = pit_pkg::MODE_SHIFT;
            pit_pkg::ST_FIND_WAIT: w_mode = pit_pkg::MODE_FIND;
            pit_pkg::ST_APPLY:     w_mode = pit_pkg::MODE_APPLY;
            default:               w_mode = pit_pkg::MODE_HOLD;
        endcase
    end

    // Request registers, entry count and response
    always_comb begin
        n_key_a     = r_key_a;
        n_key_b     = r_key_b;
        n_second    = r_second;
        n_len       = r_len;
        n_port      = r_port;
        n_phase     = r_phase;
        n_wait      = r_wait;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_res_ready;
        case (r_state)
            pit_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_wait  = '0;
                    n_phase = 1'b0;
                    case (i_req.req_type)
                        pit_pkg::REQ_INSERT: begin
                            n_key_a  = i_req.first_value;
                            n_second = i_req.second_value;
                            n_res    = '{interval_index: '0, status: pit_pkg::STAT_FULL};
                        end
                        pit_pkg::REQ_APPLY: begin
                            n_key_a = i_req.first_value & ~w_host;
                            n_key_b = i_req.first_value | w_host;
                            n_len   = w_len_sat;
                            n_port  = i_req.port_id;
                        end
                        pit_pkg::REQ_LOOKUP: begin
                            n_key_a = i_req.first_value;
                        end
                        default: begin
                            n_res = '{interval_index: '0, status: pit_pkg::STAT_OK};
                        end
                    endcase
                end
            end
            pit_pkg::ST_DUP_WAIT: begin
                n_wait = WAIT_W'(r_wait + 1'b1);
                if (w_wait_done && w_root_hit) begin
                    // Value already present: skip it
                    if (!r_phase) begin
                        n_key_a = r_second;
                        n_phase = 1'b1;
                        n_wait  = '0;
                    end else begin
                        n_res = '{interval_index: '0, status: pit_pkg::STAT_OK};
                    end
                end
            end
            pit_pkg::ST_SHIFT: begin
                n_count = CNT_W'(r_count + 1'b1);
                if (!r_phase) begin
                    n_key_a = r_second;
                    n_phase = 1'b1;
                    n_wait  = '0;
                end else begin
                    n_res = '{interval_index: '0, status: pit_pkg::STAT_OK};
                end
            end
            pit_pkg::ST_FIND_WAIT: begin
                n_wait = WAIT_W'(r_wait + 1'b1);
                if (w_wait_done) begin
                    if (w_root_hit) begin
                        n_res = '{interval_index: w_root_idx, status: pit_pkg::STAT_OK};
                    end else begin
                        n_res = '{interval_index: '0, status: pit_pkg::STAT_MISS};
                    end
                end
            end
            pit_pkg::ST_APPLY: begin
                n_res = '{interval_index: '0, status: pit_pkg::STAT_OK};
            end
            pit_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pit_pkg::ST_IDLE;
            r_phase     <= 1'b0;
            r_wait      <= '0;
            r_count     <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wait      <= n_wait;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_a  <= n_key_a;
        r_key_b  <= n_key_b;
        r_second <= n_second;
        r_len    <= n_len;
        r_port   <= n_port;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ----- rtl/pit_checker.sv -----
`default_nettype none

module pit_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          o_req_ready,
    input wire pit_pkg::t_req i_req,
    input wire logic          o_res_valid,
    input wire logic          i_res_ready,
    input wire pit_pkg::t_res o_res
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pending;

    assign w_in_acc  = i_req_valid & o_req_ready;
    assign w_out_acc = o_res_valid & i_res_ready;

    // Track requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("response changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_pending != 2'd0)
        else $error("response without a pending request");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_req_ready)
        else $error("second request taken while one is in work");

    a_status_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status != pit_pkg::STAT_OK |-> o_res.interval_index == '0)
        else $error("nonzero index on a failed request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.status == pit_pkg::STAT_OK
                     || o_res.status == pit_pkg::STAT_FULL
                     || o_res.status == pit_pkg::STAT_MISS)
        else $error("undefined status code");

endmodule

bind prefix_interval_table_unit pit_checker u_pit_checker (.*);

`default_nettype wire

// ----- tb/pit_checker.sv -----
// Watches both channels of the interval table, keeps its own copy of the
// table, and compares every response with the answer worked out for the
// matching request.
module pit_scoreboard #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire logic           i_req_ready,
    input  wire pit_pkg::t_req  i_req,
    input  wire logic           i_res_valid,
    input  wire logic           i_res_ready,
    input  wire pit_pkg::t_res  i_res,
    output int                  o_fail_count,
    output int                  o_open_count,
    output int                  o_full_count,
    output int                  o_miss_count,
    output int                  o_entry_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int SHOWN_MISMATCHES = 10;

    // Shadow copy of the table
    logic [KEY_W-1:0]  endpoints [TABLE_DEPTH];
    logic [PORT_W-1:0] ports     [TABLE_DEPTH];
    logic [LEN_W-1:0]  lengths   [TABLE_DEPTH];
    int unsigned       used = 1;

    t_res answers_due [$];
    int   mismatches = 0;
    int   refused = 0;
    int   misses = 0;
    int   open_n = 0;

    assign o_fail_count  = mismatches;
    assign o_open_count  = open_n;
    assign o_full_count  = refused;
    assign o_miss_count  = misses;
    assign o_entry_count = used;

    // Add one endpoint in sorted position unless it is already present or the table is full
    function automatic void insert_sorted(input logic [KEY_W-1:0] v);
        int unsigned pos;
        int unsigned k;
        pos = 0;
        while (pos < used && endpoints[pos] < v) pos++;
        if (pos < used && endpoints[pos] == v) return;
        if (used >= TABLE_DEPTH) return;
        for (k = used; k > pos; k--) begin
            endpoints[k] = endpoints[k - 1];
        end
        endpoints[pos] = v;
        used++;
    endfunction

    // Hand the port to every covered interval whose stored length is not longer
    function automatic void spread_port(input logic [KEY_W-1:0] addr,
                                        input logic [LEN_W-1:0] len_in,
                                        input logic [PORT_W-1:0] port);
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] host;
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        bit               covering;
        bit               walk_done;
        int unsigned      i;
        len = (len_in > FULL_LEN) ? FULL_LEN : len_in;
        host = ALL_ONES >> len;
        lo = addr & ~host;
        hi = addr | host;
        covering = 1'b0;
        walk_done = 1'b0;
        for (i = 1; i < used && !walk_done; i++) begin
            if (!covering && endpoints[i] >= lo) covering = 1'b1;
            if (covering) begin
                if (lengths[i] <= len) begin
                    lengths[i] = len;
                    ports[i] = port;
                end
                if (endpoints[i] >= hi) walk_done = 1'b1;
            end
        end
    endfunction

    // Update the shadow table with one request and return its response
    function automatic t_res table_answer(input t_req r);
        t_res        ans;
        bit          found;
        int unsigned i;
        ans.interval_index = '0;
        ans.status = STAT_OK;
        found = 1'b0;
        case (r.req_type)
            REQ_INSERT: begin
                if (used + 2 > TABLE_DEPTH) begin
                    ans.status = STAT_FULL;
                    refused++;
                end else begin
                    insert_sorted(r.first_value);
                    insert_sorted(r.second_value);
                end
            end
            REQ_APPLY: begin
                spread_port(r.first_value, r.prefix_len, r.port_id);
            end
            REQ_LOOKUP: begin
                for (i = 1; i < used && !found; i++) begin
                    if (endpoints[i] >= r.first_value) begin
                        ans.interval_index = i[OUT_IDX_W-1:0];
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    ans.status = STAT_MISS;
                    misses++;
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // Count a bad response, show the first few
    task automatic flag_response(input string why, input t_res want, input t_res got);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) begin
            $display("%0t: %s: expected index %0d status %0d, got index %0d status %0d",
                     $realtime, why, want.interval_index, want.status,
                     got.interval_index, got.status);
        end
    endtask

    // Check responses against the oldest answer, then queue answers for new requests
    always @(posedge i_clk) begin : watch
        t_res want;
        int   k;
        if (!i_rst_n) begin
            for (k = 0; k < TABLE_DEPTH; k++) begin
                endpoints[k] = '0;
                ports[k] = '0;
                lengths[k] = '0;
            end
            used = 1;
            answers_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (answers_due.size() == 0) begin
                    want = '0;
                    flag_response("response with no request waiting", want, i_res);
                end else begin
                    want = answers_due.pop_front();
                    if (i_res.interval_index !== want.interval_index ||
                        i_res.status !== want.status) begin
                        flag_response("response mismatch", want, i_res);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                answers_due.push_back(table_answer(i_req));
            end
        end
        open_n = answers_due.size();
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int TABLE_DEPTH     = 1024;
    localparam int RANDOM_REQUESTS = 1925;
    localparam int HOLD_OFF_START  = 1500;
    localparam int HOLD_OFF_SPAN   = 400;
    localparam int DRAIN_CYCLES    = 40;

    // Request code the block does not define
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_res_valid;
    logic i_res_ready;
    t_res o_res;

    int fail_n;
    int open_n;
    int full_n;
    int miss_n;
    int entries_n;

    logic [KEY_W-1:0] known_keys [$];
    int n_insert = 0;
    int n_apply = 0;
    int n_lookup = 0;
    int n_other = 0;

    always #5 i_clk = ~i_clk;

    prefix_interval_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_res      (o_res)
    );

    pit_scoreboard #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_res        (o_res),
        .o_fail_count (fail_n),
        .o_open_count (open_n),
        .o_full_count (full_n),
        .o_miss_count (miss_n),
        .o_entry_count(entries_n)
    );

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Key near the stored endpoints, near the extremes, or anywhere
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        logic [KEY_W-1:0] base;
        roll = $urandom_range(0, 99);
        if (known_keys.size() != 0 && roll < 45) begin
            base = known_keys[$urandom_range(0, known_keys.size() - 1)];
            if (roll < 30) return base;
            return $urandom_range(0, 1) ? base + 32'd1 : base - 32'd1;
        end
        if (roll < 55) return $urandom_range(0, 15);
        if (roll < 60) return ALL_ONES - $urandom_range(0, 15);
        return $urandom();
    endfunction

    function automatic t_req make_req(input logic [REQ_W-1:0] kind,
                                      input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic [LEN_W-1:0] len,
                                      input logic [PORT_W-1:0] port);
        t_req r;
        r.req_type = kind;
        r.first_value = a;
        r.second_value = b;
        r.prefix_len = len;
        r.port_id = port;
        return r;
    endfunction

    // Random request: inserts of mostly fresh keys, applies and lookups near stored keys
    function automatic t_req random_request();
        t_req             r;
        int unsigned      roll;
        logic [KEY_W-1:0] tmp;
        r = make_req(REQ_UNUSED, $urandom(), $urandom(), LEN_W'($urandom_range(0, 63)),
                     PORT_W'($urandom_range(0, 255)));
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            r.req_type = REQ_INSERT;
            if ($urandom_range(0, 99) < 20) r.first_value = pick_key();
            roll = $urandom_range(0, 99);
            if (roll < 10) r.second_value = r.first_value;
            else if (roll < 25) r.second_value = pick_key();
            if ($urandom_range(0, 99) < 70 && r.first_value > r.second_value) begin
                tmp = r.first_value;
                r.first_value = r.second_value;
                r.second_value = tmp;
            end
        end else if (roll < 72) begin
            r.req_type = REQ_APPLY;
            if ($urandom_range(0, 99) < 60) r.first_value = pick_key();
            roll = $urandom_range(0, 99);
            if (roll < 10) r.prefix_len = '0;
            else if (roll < 20) r.prefix_len = FULL_LEN;
            else if (roll < 30) r.prefix_len = LEN_W'($urandom_range(33, 63));
            else r.prefix_len = LEN_W'($urandom_range(1, 31));
        end else if (roll < 96) begin
            r.req_type = REQ_LOOKUP;
            r.first_value = pick_key();
        end
        return r;
    endfunction

    // Offer one request, hold it until taken, then maybe pause
    task automatic put_request(input t_req r);
        bit taken;
        int gap;
        i_req <= r;
        i_req_valid <= 1'b1;
        case (r.req_type)
            REQ_INSERT: begin
                n_insert++;
                known_keys.push_back(r.first_value);
                known_keys.push_back(r.second_value);
            end
            REQ_APPLY:  n_apply++;
            REQ_LOOKUP: n_lookup++;
            default:    n_other++;
        endcase
        do begin
            @(negedge i_clk);
            taken = o_req_ready;
            @(posedge i_clk);
        end while (!taken);
        gap = pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Response side: random stalls, one long hold-off to back up the request side
    initial begin : response_side
        int  span;
        int  cycles;
        bit  held;
        cycles = 0;
        held = 1'b0;
        i_res_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && cycles >= HOLD_OFF_START) begin
                held = 1'b1;
                i_res_ready <= 1'b0;
                repeat (HOLD_OFF_SPAN) @(posedge i_clk);
                cycles += HOLD_OFF_SPAN;
            end
            span = pick_gap();
            if (span > 0) begin
                i_res_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
                cycles += span;
            end
            i_res_ready <= 1'b1;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            repeat (span) @(posedge i_clk);
            cycles += span;
        end
    end

    initial begin : stimulus
        int n;
        i_rst_n <= 1'b0;
        i_req_valid <= 1'b0;
        i_req <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: lookups miss, apply and unknown do nothing
        put_request(make_req(REQ_LOOKUP, '0, ALL_ONES, '0, '0));
        put_request(make_req(REQ_LOOKUP, ALL_ONES, '0, '1, 8'hFF));
        put_request(make_req(REQ_APPLY, '0, ALL_ONES, '0, 8'hFF));
        put_request(make_req(REQ_UNUSED, ALL_ONES, ALL_ONES, '1, 8'hFF));

        // Inserts: equal pair, duplicate of entry zero, reversed pair, both present
        put_request(make_req(REQ_INSERT, 32'd10, 32'd10, '0, '0));
        put_request(make_req(REQ_INSERT, '0, ALL_ONES, '0, '0));
        put_request(make_req(REQ_INSERT, 32'd500, 32'd20, '0, '0));
        put_request(make_req(REQ_INSERT, 32'd20, 32'd10, '0, '0));

        // Lookups on the small table, down to the last endpoint
        put_request(make_req(REQ_LOOKUP, '0, '0, '0, '0));
        put_request(make_req(REQ_LOOKUP, 32'd10, '0, '0, '0));
        put_request(make_req(REQ_LOOKUP, 32'd11, '0, '0, '0));
        put_request(make_req(REQ_LOOKUP, ALL_ONES, '0, '0, '0));

        // Applies: whole range, partial range, saturated length, shorter prefix
        put_request(make_req(REQ_APPLY, 32'h0A0B_0C0D, '0, '0, 8'h5A));
        put_request(make_req(REQ_APPLY, '0, '0, 6'd24, 8'h11));
        put_request(make_req(REQ_APPLY, 32'd20, '0, 6'd63, 8'hA5));
        put_request(make_req(REQ_APPLY, '0, '0, 6'd8, 8'h33));

        // Shift entries under the stored ports, then probe again
        put_request(make_req(REQ_INSERT, 32'd15, 32'h8000_0000, '0, '0));
        put_request(make_req(REQ_APPLY, ALL_ONES, '0, FULL_LEN, 8'hC3));
        put_request(make_req(REQ_APPLY, 32'h8000_0000, '0, 6'd1, 8'h3C));
        put_request(make_req(REQ_LOOKUP, 32'h8000_0001, '0, '0, '0));
        put_request(make_req(REQ_LOOKUP, 32'd16, '0, '0, '0));
        put_request(make_req(REQ_UNUSED, '0, '0, '0, '0));

        // Random traffic; inserts fill the table and later ones are refused
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            put_request(random_request());
        end
        i_req_valid <= 1'b0;

        // Drain outstanding responses, then let the block settle
        do @(negedge i_clk); while (open_n != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("tb: %0d requests: %0d inserts, %0d applies, %0d lookups, %0d unknown",
                 n_insert + n_apply + n_lookup + n_other, n_insert, n_apply, n_lookup, n_other);
        $display("tb: table holds %0d endpoints; %0d inserts refused, %0d lookup misses, %0d bad",
                 entries_n, full_n, miss_n, fail_n);
        if (open_n != 0) begin
            $display("tb: %0d responses never arrived", open_n);
        end
        if (fail_n == 0 && open_n == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial begin : watchdog
        #(10_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
